// ===== design/amt_pkg.sv =====
// ----------------------------------------------------------------------------
// amt_pkg: shared types and codes for the address range map table
// Request and response transfer layouts, operation and status codes, and the
// per-cell control group.
// ----------------------------------------------------------------------------
`default_nettype none

package amt_pkg;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_FIND   = 2'd1,
    OP_REMOVE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] address;
    logic [31:0] region_length;
    logic [3:0]  region_type;
    logic [31:0] region_id;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  found_type;
    logic [31:0] found_id;
    logic [31:0] found_base;
    logic [31:0] found_length;
  } rsp_t;

  // Per-cell control: capture the hit flag, or load from a neighbor.
  typedef struct packed {
    logic capture;
    logic load_prev;
    logic load_next;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== design/amt_cell.sv =====
// ----------------------------------------------------------------------------
// amt_cell: one slot of the region table
// Holds one region, tests the probe address against it, and loads from either
// neighbor when the table shifts on insert or remove.
// ----------------------------------------------------------------------------
`default_nettype none

module amt_cell #(
  parameter int ADDR_WIDTH = 32
) (
  input  wire                      clk,
  input  wire                      rst,
  input  amt_pkg::cell_ctrl_t      ctrl,
  input  wire  [ADDR_WIDTH-1:0]    probe,
  input  wire                      prev_valid,
  input  wire  [3:0]               prev_type,
  input  wire  [31:0]              prev_id,
  input  wire  [ADDR_WIDTH-1:0]    prev_base,
  input  wire  [ADDR_WIDTH-1:0]    prev_length,
  input  wire                      next_valid,
  input  wire  [3:0]               next_type,
  input  wire  [31:0]              next_id,
  input  wire  [ADDR_WIDTH-1:0]    next_base,
  input  wire  [ADDR_WIDTH-1:0]    next_length,
  output logic                     valid,
  output logic [3:0]               rtype,
  output logic [31:0]              id,
  output logic [ADDR_WIDTH-1:0]    base,
  output logic [ADDR_WIDTH-1:0]    length,
  output logic                     hit
);
  import amt_pkg::*;

  logic [ADDR_WIDTH:0] offset;
  logic                contains;

  // The offset is taken with a borrow bit, so the end of the region is never
  // formed and cannot wrap.
  assign offset   = {1'b0, probe} - {1'b0, base};
  assign contains = valid && !offset[ADDR_WIDTH] && (offset[ADDR_WIDTH-1:0] < length);

  // The two loads never come together: an add and a remove exclude each other.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      hit   <= 1'b0;
    end else begin
      if (ctrl.capture) begin
        hit <= contains;
      end
      if (ctrl.load_prev) begin
        valid <= prev_valid;
      end else if (ctrl.load_next) begin
        valid <= next_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_prev) begin
      rtype  <= prev_type;
      id     <= prev_id;
      base   <= prev_base;
      length <= prev_length;
    end else if (ctrl.load_next) begin
      rtype  <= next_type;
      id     <= next_id;
      base   <= next_base;
      length <= next_length;
    end
  end

endmodule

`default_nettype wire

// ===== design/amt_pick.sv =====
// ----------------------------------------------------------------------------
// amt_pick: newest-hit selection across the cell row
// Finds the lowest slot whose hit flag is set, returns its fields, and marks
// every slot from it onward in the row for the closing shift of a remove.
// ----------------------------------------------------------------------------
`default_nettype none

module amt_pick #(
  parameter int TABLE_DEPTH = 16,
  parameter int ADDR_WIDTH  = 32
) (
  input  wire  [TABLE_DEPTH-1:0]  hit,
  input  wire  [3:0]              rtype  [TABLE_DEPTH],
  input  wire  [31:0]             id     [TABLE_DEPTH],
  input  wire  [ADDR_WIDTH-1:0]   base   [TABLE_DEPTH],
  input  wire  [ADDR_WIDTH-1:0]   length [TABLE_DEPTH],
  output logic                    any_hit,
  output logic [TABLE_DEPTH-1:0]  upto,
  output logic [3:0]              sel_type,
  output logic [31:0]             sel_id,
  output logic [ADDR_WIDTH-1:0]   sel_base,
  output logic [ADDR_WIDTH-1:0]   sel_length
);
  import amt_pkg::*;

  localparam logic [TABLE_DEPTH-1:0] ONES = {TABLE_DEPTH{1'b1}};

  logic [TABLE_DEPTH-1:0] first;

  assign any_hit = |hit;

  // Each slot looks at the hits at or before it on its own.
  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      upto[i] = |(hit & (ONES >> (TABLE_DEPTH - 1 - i)));
    end
  end

  assign first = hit & ~(upto << 1);

  always_comb begin
    sel_type   = '0;
    sel_id     = '0;
    sel_base   = '0;
    sel_length = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      sel_type   = sel_type   | ({4{first[i]}} & rtype[i]);
      sel_id     = sel_id     | ({32{first[i]}} & id[i]);
      sel_base   = sel_base   | ({ADDR_WIDTH{first[i]}} & base[i]);
      sel_length = sel_length | ({ADDR_WIDTH{first[i]}} & length[i]);
    end
  end

endmodule

`default_nettype wire

// ===== design/address_range_map_table.sv =====
// ----------------------------------------------------------------------------
// address_range_map_table: newest-first table of mapped address regions
// Each request transfer is handled in order through the sequencer states: it
// is taken in the idle state, then every slot compares the probe address
// against its region and registers a hit flag in the compare state, and in
// the update state the result is written to the response register and the
// table is updated. The update waits while a previous response has not been
// transferred. A request is taken only once the previous one has finished
// its update; a new request is taken while a finished response still waits.
// Slots form a row of cells: an add shifts every region one slot toward the
// old end and writes the new one into slot 0; a remove pulls every slot from
// the hit onward one place toward slot 0. The table is always compact.
// ----------------------------------------------------------------------------
`default_nettype none

module address_range_map_table #(
  parameter int TABLE_DEPTH = 16,
  parameter int ADDR_WIDTH  = 32
) (
  input  wire            clk,
  input  wire            rst,
  input  wire            req_valid,
  output logic           req_ready,
  input  amt_pkg::req_t  req,
  output logic           rsp_valid,
  input  wire            rsp_ready,
  output amt_pkg::rsp_t  rsp
);
  import amt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_APPLY
  } state_t;

  state_t state;
  req_t   cmd;

  // Row of cells and its view as vectors and arrays.
  logic [TABLE_DEPTH-1:0] cell_valid;
  logic [TABLE_DEPTH-1:0] cell_hit;
  logic [3:0]             cell_type   [TABLE_DEPTH];
  logic [31:0]            cell_id     [TABLE_DEPTH];
  logic [ADDR_WIDTH-1:0]  cell_base   [TABLE_DEPTH];
  logic [ADDR_WIDTH-1:0]  cell_length [TABLE_DEPTH];
  cell_ctrl_t             cell_ctrl   [TABLE_DEPTH];

  logic                   any_hit;
  logic [TABLE_DEPTH-1:0] upto;
  logic [3:0]             sel_type;
  logic [31:0]            sel_id;
  logic [ADDR_WIDTH-1:0]  sel_base;
  logic [ADDR_WIDTH-1:0]  sel_length;

  logic [ADDR_WIDTH-1:0]  cmd_addr;
  logic [ADDR_WIDTH-1:0]  cmd_len;
  logic                   go;
  logic                   add_go;
  logic                   rem_go;
  rsp_t                   result;

  // Addresses and lengths live in the table at ADDR_WIDTH bits.
  assign cmd_addr = ADDR_WIDTH'(cmd.address);
  assign cmd_len  = ADDR_WIDTH'(cmd.region_length);

  assign req_ready = (state == S_IDLE);

  // The update is done only when the response register can take the result.
  assign go     = (state == S_APPLY) && (!rsp_valid || rsp_ready);
  assign add_go = go && (cmd.opcode == OP_ADD) && !cell_valid[TABLE_DEPTH-1];
  assign rem_go = go && (cmd.opcode == OP_REMOVE) && any_hit;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic                  p_valid;
    logic [3:0]            p_type;
    logic [31:0]           p_id;
    logic [ADDR_WIDTH-1:0] p_base;
    logic [ADDR_WIDTH-1:0] p_length;
    logic                  n_valid;
    logic [3:0]            n_type;
    logic [31:0]           n_id;
    logic [ADDR_WIDTH-1:0] n_base;
    logic [ADDR_WIDTH-1:0] n_length;

    // Slot 0 takes the new region on an add; the others take their neighbor.
    if (i == 0) begin : g_head
      assign p_valid  = 1'b1;
      assign p_type   = cmd.region_type;
      assign p_id     = cmd.region_id;
      assign p_base   = cmd_addr;
      assign p_length = cmd_len;
    end else begin : g_body
      assign p_valid  = cell_valid[i-1];
      assign p_type   = cell_type[i-1];
      assign p_id     = cell_id[i-1];
      assign p_base   = cell_base[i-1];
      assign p_length = cell_length[i-1];
    end

    // The last slot empties when a remove closes the gap.
    if (i == TABLE_DEPTH - 1) begin : g_tail
      assign n_valid  = 1'b0;
      assign n_type   = '0;
      assign n_id     = '0;
      assign n_base   = '0;
      assign n_length = '0;
    end else begin : g_inner
      assign n_valid  = cell_valid[i+1];
      assign n_type   = cell_type[i+1];
      assign n_id     = cell_id[i+1];
      assign n_base   = cell_base[i+1];
      assign n_length = cell_length[i+1];
    end

    assign cell_ctrl[i].capture   = (state == S_MATCH);
    assign cell_ctrl[i].load_prev = add_go;
    assign cell_ctrl[i].load_next = rem_go && upto[i];

    amt_cell #(
      .ADDR_WIDTH (ADDR_WIDTH)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (cell_ctrl[i]),
      .probe       (cmd_addr),
      .prev_valid  (p_valid),
      .prev_type   (p_type),
      .prev_id     (p_id),
      .prev_base   (p_base),
      .prev_length (p_length),
      .next_valid  (n_valid),
      .next_type   (n_type),
      .next_id     (n_id),
      .next_base   (n_base),
      .next_length (n_length),
      .valid       (cell_valid[i]),
      .rtype       (cell_type[i]),
      .id          (cell_id[i]),
      .base        (cell_base[i]),
      .length      (cell_length[i]),
      .hit         (cell_hit[i])
    );
  end

  amt_pick #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ADDR_WIDTH  (ADDR_WIDTH)
  ) u_pick (
    .hit        (cell_hit),
    .rtype      (cell_type),
    .id         (cell_id),
    .base       (cell_base),
    .length     (cell_length),
    .any_hit    (any_hit),
    .upto       (upto),
    .sel_type   (sel_type),
    .sel_id     (sel_id),
    .sel_base   (sel_base),
    .sel_length (sel_length)
  );

  // Response contents. Only a find that hits returns the region fields; an
  // unused opcode returns OK and changes nothing.
  always_comb begin
    result = '0;
    unique case (cmd.opcode)
      OP_ADD: begin
        result.status = cell_valid[TABLE_DEPTH-1] ? ST_FULL : ST_OK;
      end
      OP_FIND: begin
        if (any_hit) begin
          result.status       = ST_OK;
          result.found_type   = sel_type;
          result.found_id     = sel_id;
          result.found_base   = 32'(sel_base);
          result.found_length = 32'(sel_length);
        end else begin
          result.status = ST_MISS;
        end
      end
      OP_REMOVE: begin
        result.status = any_hit ? ST_OK : ST_MISS;
      end
      default: begin
        result.status = ST_OK;
      end
    endcase
  end

  // Sequencer with the request and response registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            state <= S_MATCH;
          end
        end
        S_MATCH: begin
          state <= S_APPLY;
        end
        S_APPLY: begin
          if (go) begin
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      cmd <= req;
    end
    if (go) begin
      rsp <= result;
    end
  end

  // A taken request always moves on to the compare cycle.
  a_accept_to_match: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> (state == S_MATCH))
    else $error("request transfer did not start a compare cycle");

  // Valid slots always form a run starting at slot 0.
  a_compact: assert property (@(posedge clk) disable iff (rst)
    ((cell_valid + 1'b1) & cell_valid) == '0)
    else $error("region table is not compact");

  // A response appears only out of the update cycle.
  a_rsp_from_apply: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == S_APPLY))
    else $error("response raised outside the update cycle");

  // A find never changes which slots are in use.
  a_find_keeps_table: assert property (@(posedge clk) disable iff (rst)
    (go && cmd.opcode == OP_FIND) |=> $stable(cell_valid))
    else $error("find changed the table");

endmodule

`default_nettype wire
